// ===== rtl/fprv_pkg.sv =====
// Shared types and constants for the periodogram and RMS velocity core.
// Holds the word structs, configuration codes, sequencer states and unit request types.
// No dependencies.
package fprv_pkg;

  localparam int unsigned MAX_FFT_SIZE_DEF = 4096;

  localparam int unsigned FFT_SIZE_W    = 13;
  localparam int unsigned SAMPLE_RATE_W = 12;
  localparam int unsigned CFG_DATA_W    = 13;
  localparam int unsigned CFG_INDEX_W   = 2;

  localparam logic [FFT_SIZE_W-1:0] FFT_SIZE_RESET = 13'd1024;
  localparam logic [30:0]           PI_Q29         = 31'd1686629713;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FFT_SIZE    = 2'd0,
    REG_SAMPLE_RATE = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] word_real;
    logic signed [31:0] word_imag;
  } in_word_t;

  typedef struct packed {
    logic [11:0] bin_number;
    logic [27:0] bin_frequency;
    logic [31:0] magnitude;
    logic [63:0] power_density;
    logic [31:0] rms_speed;
    logic        last;
  } out_word_t;

  typedef enum logic {
    OP_DIV,
    OP_SQRT
  } unit_op_t;

  typedef struct packed {
    logic        start;
    unit_op_t    op;
    logic [63:0] num;
    logic [63:0] den;
  } unit_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] result;
  } unit_resp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQ_A,
    ST_SQ_B,
    ST_SQ_C,
    ST_TERM,
    ST_MAG,
    ST_NFS,
    ST_PSD,
    ST_FSO,
    ST_FREQ,
    ST_FREQ_DONE,
    ST_ROOT,
    ST_FSPI,
    ST_RMS,
    ST_RMS_DONE,
    ST_OUT,
    ST_WAIT
  } seq_state_t;

endpackage

// ===== rtl/fprv_mul.sv =====
// Registered 32x32 unsigned multiplier shared by the sequencer.
// Product appears in the cycle after the operands.
// Depends on nothing.
module fprv_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// ===== rtl/fprv_divsqrt.sv =====
// Iterative shift-subtract unit: 64/64 restoring divide (64 steps) or
// 64-bit integer square root (32 steps), one step per cycle.
// Depends on fprv_pkg.
module fprv_divsqrt (
  input  logic                  clk,
  input  logic                  rst,
  input  fprv_pkg::unit_req_t   req,
  output fprv_pkg::unit_resp_t  resp
);
  import fprv_pkg::*;

  logic        busy;
  logic        done;
  logic [5:0]  cnt;
  unit_op_t    op;
  logic [65:0] acc;
  logic [63:0] rad;
  logic [63:0] res;
  logic [63:0] den;
  logic [65:0] acc_sh;
  logic [65:0] trial;
  logic        fit;

  always_comb begin
    if (op == OP_DIV) begin
      acc_sh = {acc[64:0], rad[63]};
      trial  = {2'b00, den};
    end else begin
      acc_sh = {acc[63:0], rad[63:62]};
      trial  = {res, 2'b01};
    end
    fit = (acc_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == 6'd0);
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= (req.op == OP_DIV) ? 6'd63 : 6'd31;
      end else if (busy) begin
        if (cnt == 6'd0) begin
          busy <= 1'b0;
        end
        cnt <= cnt - 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op  <= req.op;
      den <= req.den;
      rad <= req.num;
      acc <= '0;
      res <= '0;
    end else if (busy) begin
      acc <= fit ? (acc_sh - trial) : acc_sh;
      res <= {res[62:0], fit};
      rad <= (op == OP_DIV) ? {rad[62:0], 1'b0} : {rad[61:0], 2'b00};
    end
  end

  assign resp.done   = done;
  assign resp.result = res;

endmodule

// ===== rtl/fft_psd_rms_velocity_core.sv =====
// Periodogram and RMS velocity core: one bin per word pair, Nyquist bin closes the frame.
// Each bin runs three 64-step divides and one 32-step root on the shared shift-subtract
// unit; the closing bin adds the RMS root and divide. Input is taken only while the
// sequencer is idle; one result may wait in the output register meanwhile.
// Synchronous reset: fft_size 1024, sample_rate 0, frame state cleared.
module fft_psd_rms_velocity_core #(
  parameter int unsigned MAX_FFT_SIZE = fprv_pkg::MAX_FFT_SIZE_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_en,
  input  logic [fprv_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [fprv_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  fprv_pkg::in_word_t                 in_word,
  output logic                               out_valid,
  input  logic                               out_ready,
  output fprv_pkg::out_word_t                out_word
);
  import fprv_pkg::*;

  function automatic logic [31:0] abs32(input logic [31:0] w);
    abs32 = w[31] ? (~w + 32'd1) : w;
  endfunction

  function automatic logic [12:0] odd_of(input logic [11:0] k);
    odd_of = {k, 1'b0} - 13'd1;
  endfunction

  seq_state_t state;
  seq_state_t state_next;
  seq_state_t ret_state;

  logic [FFT_SIZE_W-1:0]    fft_size;
  logic [SAMPLE_RATE_W-1:0] sample_rate;
  logic [11:0]              pair_count;
  logic [31:0]              nyquist_word;
  logic [63:0]              velocity_sum;

  logic [12:0] n_eff;
  logic [11:0] pairs;
  logic        in_take;
  logic        active;
  logic        first;
  logic        ends;
  logic        load;
  logic [64:0] vsum_add;

  logic [63:0] s_val;
  logic [31:0] mag;
  logic [63:0] psd;
  logic [27:0] freq;
  logic [31:0] root;
  logic [31:0] rms;
  logic [11:0] k;
  logic [12:0] odd;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic        is_last;
  logic        nyq_pending;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;
  unit_req_t   req;
  unit_resp_t  resp;

  fprv_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  fprv_divsqrt u_divsqrt (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .resp (resp)
  );

  always_comb begin
    n_eff = fft_size;
    if (fft_size < 13'd2) begin
      n_eff = 13'd2;
    end
    if (32'(fft_size) > MAX_FFT_SIZE) begin
      n_eff = 13'(MAX_FFT_SIZE);
    end
  end

  assign pairs    = n_eff[12:1];
  assign in_ready = (state == ST_IDLE);
  assign in_take  = in_valid && in_ready;
  assign active   = (sample_rate != '0);
  assign first    = (pair_count == 12'd0);
  assign ends     = (({1'b0, pair_count} + 13'd1) >= {1'b0, pairs});
  assign load     = (state == ST_OUT) && (!out_valid || out_ready);
  assign vsum_add = {1'b0, velocity_sum} + {1'b0, resp.result};

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_take && active && !(first && !ends)) begin
          state_next = ST_SQ_A;
        end
      end
      ST_SQ_A:      state_next = ST_SQ_B;
      ST_SQ_B:      state_next = ST_SQ_C;
      ST_SQ_C:      state_next = ST_TERM;
      ST_TERM:      state_next = ST_WAIT;
      ST_MAG:       state_next = ST_WAIT;
      ST_NFS:       state_next = ST_PSD;
      ST_PSD:       state_next = ST_WAIT;
      ST_FSO:       state_next = ST_FREQ;
      ST_FREQ:      state_next = ST_WAIT;
      ST_FREQ_DONE: state_next = is_last ? ST_ROOT : ST_OUT;
      ST_ROOT:      state_next = ST_WAIT;
      ST_FSPI:      state_next = ST_RMS;
      ST_RMS:       state_next = ST_WAIT;
      ST_RMS_DONE:  state_next = ST_OUT;
      ST_OUT: begin
        if (load) begin
          state_next = (!is_last && nyq_pending) ? ST_SQ_A : ST_IDLE;
        end
      end
      ST_WAIT: begin
        if (resp.done) begin
          state_next = ret_state;
        end
      end
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    req.start = 1'b0;
    req.op    = OP_DIV;
    req.num   = '0;
    req.den   = '0;
    case (state)
      ST_SQ_A: begin
        mul_a = op_a;
        mul_b = op_a;
      end
      ST_SQ_B: begin
        mul_a = op_b;
        mul_b = op_b;
      end
      ST_SQ_C: begin
        mul_a = 32'(odd);
        mul_b = 32'(odd);
      end
      ST_TERM: begin
        req.start = 1'b1;
        req.num   = s_val;
        req.den   = mul_p;
      end
      ST_MAG: begin
        req.start = 1'b1;
        req.op    = OP_SQRT;
        req.num   = s_val;
      end
      ST_NFS: begin
        mul_a = 32'(n_eff);
        mul_b = 32'(sample_rate);
      end
      ST_PSD: begin
        req.start = 1'b1;
        req.num   = s_val;
        req.den   = mul_p;
      end
      ST_FSO: begin
        mul_a = 32'(sample_rate);
        mul_b = 32'(odd);
      end
      ST_FREQ: begin
        req.start = 1'b1;
        req.num   = {mul_p[48:0], 15'd0};
        req.den   = 64'(n_eff);
      end
      ST_ROOT: begin
        req.start = 1'b1;
        req.op    = OP_SQRT;
        req.num   = velocity_sum;
      end
      ST_FSPI: begin
        mul_a = 32'(sample_rate);
        mul_b = 32'(PI_Q29);
      end
      ST_RMS: begin
        req.start = 1'b1;
        req.num   = {3'd0, root, 29'd0};
        req.den   = mul_p;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      out_valid    <= 1'b0;
      fft_size     <= FFT_SIZE_RESET;
      sample_rate  <= '0;
      pair_count   <= '0;
      nyquist_word <= '0;
      velocity_sum <= '0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (in_take && active) begin
        if (first) begin
          nyquist_word <= in_word.word_imag;
          velocity_sum <= '0;
        end
        pair_count <= ends ? 12'd0 : (pair_count + 12'd1);
      end
      if (state == ST_MAG) begin
        velocity_sum <= vsum_add[64] ? '1 : vsum_add[63:0];
      end
      if (cfg_en) begin
        if (cfg_index == REG_FFT_SIZE) begin
          fft_size   <= cfg_data;
          pair_count <= '0;
        end else if (cfg_index == REG_SAMPLE_RATE) begin
          sample_rate <= cfg_data[SAMPLE_RATE_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_take && active) begin
          nyq_pending <= ends;
          if (!first) begin
            k       <= pair_count;
            odd     <= odd_of(pair_count);
            op_a    <= abs32(in_word.word_real);
            op_b    <= abs32(in_word.word_imag);
            is_last <= 1'b0;
          end else begin
            k       <= pairs;
            odd     <= odd_of(pairs);
            op_a    <= '0;
            op_b    <= abs32(in_word.word_imag);
            is_last <= 1'b1;
          end
        end
      end
      ST_SQ_B:      s_val <= mul_p;
      ST_SQ_C:      s_val <= s_val + mul_p;
      ST_TERM:      ret_state <= ST_MAG;
      ST_MAG:       ret_state <= ST_NFS;
      ST_NFS:       mag <= resp.result[31:0];
      ST_PSD:       ret_state <= ST_FSO;
      ST_FSO:       psd <= resp.result;
      ST_FREQ:      ret_state <= ST_FREQ_DONE;
      ST_FREQ_DONE: freq <= resp.result[27:0];
      ST_ROOT:      ret_state <= ST_FSPI;
      ST_FSPI:      root <= resp.result[31:0];
      ST_RMS:       ret_state <= ST_RMS_DONE;
      ST_RMS_DONE:  rms <= (|resp.result[63:32]) ? '1 : resp.result[31:0];
      ST_OUT: begin
        if (load) begin
          out_word.bin_number    <= k;
          out_word.bin_frequency <= freq;
          out_word.magnitude     <= mag;
          out_word.power_density <= psd;
          out_word.rms_speed     <= is_last ? rms : 32'd0;
          out_word.last          <= is_last;
          if (!is_last && nyq_pending) begin
            k       <= pairs;
            odd     <= odd_of(pairs);
            op_a    <= '0;
            op_b    <= abs32(nyquist_word);
            is_last <= 1'b1;
          end
        end
      end
      default: begin
        s_val <= s_val;
      end
    endcase
  end

endmodule
